// File: sv/brfc_pkg.sv
// ----------------------------------------------------------------------------
// brfc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the response
// frame checker.
// ----------------------------------------------------------------------------
package brfc_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int CRC_SPAN    = FRAME_BYTES - 2;
    localparam int CNT_SAT     = FRAME_BYTES + 1;
    localparam int CNT_W       = $clog2(CNT_SAT + 1);
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0]  START_FIRST_RST  = 8'h55;
    localparam logic [7:0]  START_SECOND_RST = 8'hAA;
    localparam logic [15:0] ACK_RST          = 16'h0010;
    localparam logic [15:0] NACK_RST         = 16'h0011;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_FIRST  = 2'd0,
        CFG_START_SECOND = 2'd1,
        CFG_ACK_CODE     = 2'd2,
        CFG_NACK_CODE    = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SIZE  = 3'd1,
        ST_START = 3'd2,
        ST_CMD   = 3'd3,
        ST_LEN   = 3'd4,
        ST_CRC   = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0]  start_first;
        logic [7:0]  start_second;
        logic [15:0] ack_code;
        logic [15:0] nack_code;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [15:0] response_command;
        logic [15:0] request_command;
        logic [15:0] result_code;
        logic [31:0] extra_value;
    } t_result;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/brfc_in_if.sv
// ----------------------------------------------------------------------------
// brfc_in_if
// Byte channel into the frame checker: one frame byte and a final-byte flag.
// ----------------------------------------------------------------------------
interface brfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// File: sv/brfc_out_if.sv
// ----------------------------------------------------------------------------
// brfc_out_if
// Result channel out of the frame checker: status and decoded frame fields.
// ----------------------------------------------------------------------------
interface brfc_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] response_command;
    logic [15:0] request_command;
    logic [15:0] result_code;
    logic [31:0] extra_value;

    modport source (output valid, output status, output response_command,
                    output request_command, output result_code, output extra_value,
                    input ready);
    modport sink   (input valid, input status, input response_command,
                    input request_command, input result_code, input extra_value,
                    output ready);
endinterface

// File: sv/brfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// brfc_cfg_regs
// Configuration registers: start bytes and acknowledge command codes.
// ----------------------------------------------------------------------------
module brfc_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [brfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [brfc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output brfc_pkg::t_cfg                  o_cfg
);

    brfc_pkg::t_cfg r_cfg;
    brfc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (brfc_pkg::t_cfg_index'(i_cfg_index))
                brfc_pkg::CFG_START_FIRST:  n_cfg.start_first  = i_cfg_data[7:0];
                brfc_pkg::CFG_START_SECOND: n_cfg.start_second = i_cfg_data[7:0];
                brfc_pkg::CFG_ACK_CODE:     n_cfg.ack_code     = i_cfg_data;
                brfc_pkg::CFG_NACK_CODE:    n_cfg.nack_code    = i_cfg_data;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_first  <= brfc_pkg::START_FIRST_RST;
            r_cfg.start_second <= brfc_pkg::START_SECOND_RST;
            r_cfg.ack_code     <= brfc_pkg::ACK_RST;
            r_cfg.nack_code    <= brfc_pkg::NACK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/brfc_frame.sv
// ----------------------------------------------------------------------------
// brfc_frame
// Input register, byte counter, running CRC, frame byte store and the
// end-of-frame checks that produce one result per flagged byte.
// ----------------------------------------------------------------------------
module brfc_frame (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  brfc_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_ready,
    input  logic               i_out_free,
    output logic               o_res_load,
    output brfc_pkg::t_result  o_result
);

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_last;
    logic [brfc_pkg::CNT_W-1:0] r_cnt;
    logic [brfc_pkg::CNT_W-1:0] n_cnt;
    logic [15:0]                r_crc;
    logic [15:0]                n_crc;
    logic [7:0]                 r_store [brfc_pkg::FRAME_BYTES];
    logic [7:0]                 n_store [brfc_pkg::FRAME_BYTES];
    logic                       w_advance;
    logic [15:0]                w_cmd;
    brfc_pkg::t_result          n_result;

    assign w_advance = r_in_valid && (!r_in_last || i_out_free);
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < brfc_pkg::FRAME_BYTES; i++) begin
            n_store[i] = (r_cnt == brfc_pkg::CNT_W'(i)) ? r_in_byte : r_store[i];
        end
        n_crc = (r_cnt < brfc_pkg::CNT_W'(brfc_pkg::CRC_SPAN))
              ? brfc_pkg::crc16_feed(r_crc, r_in_byte) : r_crc;
        n_cnt = (r_cnt < brfc_pkg::CNT_W'(brfc_pkg::CNT_SAT)) ? r_cnt + 1'b1 : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_cnt < brfc_pkg::CNT_W'(brfc_pkg::FRAME_BYTES)) begin
            r_store[r_cnt[brfc_pkg::IDX_W-1:0]] <= r_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_crc <= brfc_pkg::CRC_INIT;
        end else if (w_advance) begin
            if (r_in_last) begin
                r_cnt <= '0;
                r_crc <= brfc_pkg::CRC_INIT;
            end else begin
                r_cnt <= n_cnt;
                r_crc <= n_crc;
            end
        end
    end

    assign w_cmd = {n_store[3], n_store[2]};

    always_comb begin
        n_result = '0;
        if (n_cnt != brfc_pkg::CNT_W'(brfc_pkg::FRAME_BYTES)) begin
            n_result.status = brfc_pkg::ST_SIZE;
        end else if (n_store[0] != i_cfg.start_first || n_store[1] != i_cfg.start_second) begin
            n_result.status = brfc_pkg::ST_START;
        end else if (w_cmd != i_cfg.ack_code && w_cmd != i_cfg.nack_code) begin
            n_result.status = brfc_pkg::ST_CMD;
        end else if ({n_store[5], n_store[4]} != 16'(brfc_pkg::FRAME_BYTES)) begin
            n_result.status = brfc_pkg::ST_LEN;
        end else if ({n_store[15], n_store[14]} != n_crc) begin
            n_result.status = brfc_pkg::ST_CRC;
        end else begin
            n_result.status           = brfc_pkg::ST_OK;
            n_result.response_command = w_cmd;
            n_result.request_command  = {n_store[7], n_store[6]};
            n_result.result_code      = {n_store[9], n_store[8]};
            n_result.extra_value      = {n_store[13], n_store[12], n_store[11], n_store[10]};
        end
    end

    assign o_res_load = w_advance && r_in_last;
    assign o_result   = n_result;

endmodule

// File: sv/brfc_out_reg.sv
// ----------------------------------------------------------------------------
// brfc_out_reg
// Result register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module brfc_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  brfc_pkg::t_result i_result,
    output logic              o_free,
    brfc_out_if.source        o_res
);

    logic              r_valid;
    brfc_pkg::t_result r_result;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.status           = r_result.status;
    assign o_res.response_command = r_result.response_command;
    assign o_res.request_command  = r_result.request_command;
    assign o_res.result_code      = r_result.result_code;
    assign o_res.extra_value      = r_result.extra_value;

endmodule

// File: sv/boot_response_frame_checker.sv
// ----------------------------------------------------------------------------
// boot_response_frame_checker
// Checks 16-byte response frames (start bytes, command, length, CRC-16/MODBUS)
// and reports one status and decoded fields per frame.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle with no gaps needed between frames; the CRC
// is updated by an eight-bit unrolled step in the same cycle the byte leaves
// the input register. When a frame's final byte leaves the input register,
// its result is loaded into the output register, which lets the next
// frame's bytes keep flowing while a result waits. Only a final byte
// stalls, and only while the previous result is still held.
module boot_response_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    brfc_in_if.sink                         i_frame,
    brfc_out_if.source                      o_result,
    input  logic                            i_cfg_we,
    input  logic [brfc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [brfc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    brfc_pkg::t_cfg    w_cfg;
    brfc_pkg::t_result w_result;
    logic              w_res_load;
    logic              w_out_free;

    brfc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    brfc_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (i_frame.valid),
        .i_data_byte (i_frame.data_byte),
        .i_last_byte (i_frame.last_byte),
        .o_ready     (i_frame.ready),
        .i_out_free  (w_out_free),
        .o_res_load  (w_res_load),
        .o_result    (w_result)
    );

    brfc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_res_load),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_res    (o_result)
    );

endmodule

// File: sv/brfc_checker.sv
// ----------------------------------------------------------------------------
// brfc_checker
// Port-level checks on the result channel of the frame checker.
// ----------------------------------------------------------------------------
module brfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_status,
    input logic [15:0] i_response_command,
    input logic [15:0] i_request_command,
    input logic [15:0] i_result_code,
    input logic [31:0] i_extra_value
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result dropped while stalled");

    a_hold_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_status))
        else $error("status changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_status <= 3'(brfc_pkg::ST_CRC))
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != 3'(brfc_pkg::ST_OK) |->
            i_response_command == '0 && i_request_command == '0 &&
            i_result_code == '0 && i_extra_value == '0)
        else $error("failed frame carries nonzero fields");

endmodule

bind boot_response_frame_checker brfc_checker u_brfc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (o_result.valid),
    .i_ready            (o_result.ready),
    .i_status           (o_result.status),
    .i_response_command (o_result.response_command),
    .i_request_command  (o_result.request_command),
    .i_result_code      (o_result.result_code),
    .i_extra_value      (o_result.extra_value)
);
